[src/gcbe_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package gcbe_pkg;

    localparam int unsigned DEF_MAX_SPREAD = 8;

    localparam int unsigned COV_W   = 8;
    localparam int unsigned PIX_W   = 32;
    localparam int unsigned FG_W    = 24;
    localparam int unsigned SPREAD_W = 4;
    localparam int unsigned CFG_IDX_W = 3;
    localparam int unsigned CFG_DAT_W = 32;

    localparam logic [PIX_W-1:0] ZERO_BASE   = 32'h8080_8080;
    localparam logic [PIX_W-1:0] BG_RESET    = 32'h8080_8080;
    localparam logic [7:0]       CHAN_MAX    = 8'hFF;
    localparam logic [SPREAD_W-1:0] SPREAD_RESET = 4'd1;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_FG_COLOR     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BG_COLOR     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PER_PIXEL_BG = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_EMBOLDEN     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SPREAD_WIDTH = 3'd4;

    typedef struct packed {
        logic                embolden;
        logic [SPREAD_W-1:0] spread_width;
    } t_win_cfg;

    typedef struct packed {
        logic [FG_W-1:0]  fg_color;
        logic [PIX_W-1:0] fixed_bg;
        logic             per_pixel_bg;
    } t_blend_cfg;

endpackage

`default_nettype wire

[src/gcbe_window.sv]
`timescale 1ns / 1ps
`default_nettype none

module gcbe_window #(
    parameter int unsigned MAX_SPREAD = gcbe_pkg::DEF_MAX_SPREAD
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire gcbe_pkg::t_win_cfg          i_cfg,
    input  wire logic                        i_take,
    input  wire logic [gcbe_pkg::COV_W-1:0]  i_coverage,
    input  wire logic                        i_row_start,
    output logic      [gcbe_pkg::COV_W-1:0]  o_coverage_eff
);
    import gcbe_pkg::*;

    logic [COV_W-1:0] r_win [MAX_SPREAD];
    logic [COV_W-1:0] n_win [MAX_SPREAD];
    logic [COV_W-1:0] cov_max;

    // running maximum over the enabled window taps
    always_comb begin
        cov_max = i_coverage;
        if (i_cfg.embolden && !i_row_start) begin
            for (int i = 0; i < int'(MAX_SPREAD); i++) begin
                if ((i == 0 || 32'(i) < 32'(i_cfg.spread_width)) && r_win[i] > cov_max) begin
                    cov_max = r_win[i];
                end
            end
        end
    end

    assign o_coverage_eff = cov_max;

    // shift in the raw byte, row start drops older taps
    always_comb begin
        n_win[0] = i_coverage;
        for (int i = 1; i < int'(MAX_SPREAD); i++) begin
            n_win[i] = i_row_start ? '0 : r_win[i-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < int'(MAX_SPREAD); i++) begin
                r_win[i] <= '0;
            end
        end else if (i_take) begin
            for (int i = 0; i < int'(MAX_SPREAD); i++) begin
                r_win[i] <= n_win[i];
            end
        end
    end

endmodule

`default_nettype wire

[src/gcbe_blend.sv]
`timescale 1ns / 1ps
`default_nettype none

module gcbe_blend (
    input  wire gcbe_pkg::t_blend_cfg        i_cfg,
    input  wire logic [gcbe_pkg::COV_W-1:0]  i_coverage,
    input  wire logic [gcbe_pkg::PIX_W-1:0]  i_dest_pixel,
    output logic                             o_write_enable,
    output logic      [gcbe_pkg::PIX_W-1:0]  o_new_pixel
);
    import gcbe_pkg::*;

    logic [PIX_W-1:0] base_sel;
    logic [PIX_W-1:0] base;
    logic [8:0]       alpha_sum;
    logic [7:0]       alpha;
    logic [7:0]       chan [3];

    // base + (fg - base) * cov / 256, quotient truncated toward zero
    function automatic logic [7:0] blend_chan(input logic [7:0] b, input logic [7:0] f,
                                              input logic [7:0] c);
        logic signed [8:0]  diff;
        logic signed [17:0] prod;
        logic signed [17:0] q;
        logic signed [17:0] sum;
        diff = $signed({1'b0, f}) - $signed({1'b0, b});
        prod = 18'(diff * $signed({1'b0, c}));
        q    = prod[17] ? ((prod + 18'sd255) >>> 8) : (prod >>> 8);
        sum  = $signed({10'd0, b}) + q;
        return sum[7:0];
    endfunction

    always_comb begin
        base_sel  = i_cfg.per_pixel_bg ? i_dest_pixel : i_cfg.fixed_bg;
        base      = (base_sel == '0) ? ZERO_BASE : base_sel;
        alpha_sum = {1'b0, base[31:24]} + {1'b0, i_coverage};
        alpha     = alpha_sum[8] ? CHAN_MAX : alpha_sum[7:0];
        for (int k = 0; k < 3; k++) begin
            chan[k] = blend_chan(base[8*k +: 8], i_cfg.fg_color[8*k +: 8], i_coverage);
        end
        o_write_enable = (i_coverage != '0);
        o_new_pixel    = o_write_enable ? {alpha, chan[2], chan[1], chan[0]} : '0;
    end

endmodule

`default_nettype wire

[src/glyph_coverage_blend_embolden.sv]
`timescale 1ns / 1ps
`default_nettype none
// throughput: one transaction per cycle while i_m_tready holds; a two-register pipeline with a chained stall
// the running maximum settles in the input stage, the three 9x9 blend multiplies in the second
// reset: synchronous active low; clears valids, the coverage window and config registers
// (fixed background resets to 0x80808080, spread_width to 1, the rest to zero)

module glyph_coverage_blend_embolden #(
    parameter int unsigned MAX_SPREAD = gcbe_pkg::DEF_MAX_SPREAD
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    // configuration write port
    input  wire logic                              i_cfg_wr_en,
    input  wire logic [gcbe_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  wire logic [gcbe_pkg::CFG_DAT_W-1:0]    i_cfg_data,
    // slave side
    input  wire logic                              i_s_tvalid,
    output logic                                   o_s_tready,
    input  wire logic [39:0]                       i_s_tdata,  // coverage[7:0], dest_pixel[39:8]
    input  wire logic                              i_s_tuser,  // row_start
    // master side
    output logic                                   o_m_tvalid,
    input  wire logic                              i_m_tready,
    output logic      [31:0]                       o_m_tdata,  // new_pixel[31:0]
    output logic                                   o_m_tuser   // write_enable
);
    import gcbe_pkg::*;

    // configuration registers
    logic [FG_W-1:0]     r_fg_color;
    logic [PIX_W-1:0]    r_fixed_bg;
    logic                r_per_pixel_bg;
    logic                r_embolden;
    logic [SPREAD_W-1:0] r_spread_width;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fg_color     <= '0;
            r_fixed_bg     <= BG_RESET;
            r_per_pixel_bg <= 1'b0;
            r_embolden     <= 1'b0;
            r_spread_width <= SPREAD_RESET;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                CFG_FG_COLOR:     r_fg_color     <= i_cfg_data[FG_W-1:0];
                CFG_BG_COLOR:     r_fixed_bg     <= i_cfg_data[PIX_W-1:0];
                CFG_PER_PIXEL_BG: r_per_pixel_bg <= i_cfg_data[0];
                CFG_EMBOLDEN:     r_embolden     <= i_cfg_data[0];
                CFG_SPREAD_WIDTH: r_spread_width <= i_cfg_data[SPREAD_W-1:0];
                default: ;  // unmapped index, write dropped
            endcase
        end
    end

    t_win_cfg   win_cfg;
    t_blend_cfg blend_cfg;

    assign win_cfg.embolden        = r_embolden;
    assign win_cfg.spread_width    = r_spread_width;
    assign blend_cfg.fg_color      = r_fg_color;
    assign blend_cfg.fixed_bg      = r_fixed_bg;
    assign blend_cfg.per_pixel_bg  = r_per_pixel_bg;

    // pipeline handshake: each stage moves when the one after it is empty or draining
    logic r_s1_valid;
    logic r_out_valid;
    logic out_free;
    logic s1_free;
    logic in_take;

    assign out_free   = !r_out_valid || i_m_tready;
    assign s1_free    = !r_s1_valid || out_free;
    assign o_s_tready = s1_free;
    assign in_take    = i_s_tvalid && s1_free;

    // stage 1: window maximum feeds the input register
    logic [COV_W-1:0] cov_eff;

    gcbe_window #(
        .MAX_SPREAD (MAX_SPREAD)
    ) u_window (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg          (win_cfg),
        .i_take         (in_take),
        .i_coverage     (i_s_tdata[7:0]),
        .i_row_start    (i_s_tuser),
        .o_coverage_eff (cov_eff)
    );

    logic [COV_W-1:0] r_s1_cov;
    logic [PIX_W-1:0] r_s1_dest;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (s1_free) begin
            r_s1_valid <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_s1_cov  <= cov_eff;
            r_s1_dest <= i_s_tdata[39:8];
        end
    end

    // stage 2: blend into the result register
    logic             blend_we;
    logic [PIX_W-1:0] blend_pix;

    gcbe_blend u_blend (
        .i_cfg          (blend_cfg),
        .i_coverage     (r_s1_cov),
        .i_dest_pixel   (r_s1_dest),
        .o_write_enable (blend_we),
        .o_new_pixel    (blend_pix)
    );

    logic             r_out_we;
    logic [PIX_W-1:0] r_out_pix;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free && r_s1_valid) begin
            r_out_we  <= blend_we;
            r_out_pix <= blend_pix;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_pix;
    assign o_m_tuser  = r_out_we;

endmodule

`default_nettype wire

[sim/glyph_blend_checker.sv]
`timescale 1ns / 1ps

module glyph_blend_checker (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_wr_en,
    input  logic [gcbe_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [gcbe_pkg::CFG_DAT_W-1:0]  i_cfg_data,
    input  logic                            i_s_tvalid,
    input  logic                            i_s_tready,
    input  logic [39:0]                     i_s_tdata,  // coverage[7:0], dest_pixel[39:8]
    input  logic                            i_s_tuser,  // row_start
    input  logic                            i_m_tvalid,
    input  logic                            i_m_tready,
    input  logic [31:0]                     i_m_tdata,  // new_pixel[31:0]
    input  logic                            i_m_tuser,  // write_enable
    output int                              o_mismatches,
    output int                              o_pending,
    output int                              o_results,
    output int                              o_writes
);
    import gcbe_pkg::*;

    localparam int WINDOW = DEF_MAX_SPREAD;
    localparam int REPORT_LIMIT = 30;

    typedef struct packed {
        logic        write_en;
        logic [31:0] pixel;
    } t_blend_result;

    // shadow of the configuration registers
    logic [FG_W-1:0]     fg_rgb;
    logic [PIX_W-1:0]    bg_argb;
    logic                over_dest;
    logic                widen;
    logic [SPREAD_W-1:0] spread_reg;

    logic [7:0]          cov_history [WINDOW];
    t_blend_result       expected_pixels [$];
    t_blend_result       seen, due;
    int                  mismatches = 0;
    int                  results = 0;
    int                  writes = 0;

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        if (mismatches < REPORT_LIMIT)
            $display("%0t: result %0d %s mismatch: got %h, expected %h",
                     $time, results, what, got, want);
        mismatches++;
    endtask

    function automatic logic [7:0] mix_channel(input logic [7:0] base, input logic [7:0] fg,
                                               input logic [7:0] cov);
        int diff;
        int prod;
        diff = int'(fg) - int'(base);
        prod = diff * int'(cov);
        // signed int division truncates toward zero
        return 8'(int'(base) + prod / 256);
    endfunction

    task automatic predict_pixel(input logic [7:0] cov_in, input logic [31:0] dest,
                                 input logic row_start);
        logic [7:0]    cov;
        logic [31:0]   base;
        logic [8:0]    alpha;
        int            span;
        int            k;
        t_blend_result r;
        if (row_start)
            foreach (cov_history[j]) cov_history[j] = '0;
        span = (spread_reg == 0) ? 1 : ((spread_reg > WINDOW) ? WINDOW : int'(spread_reg));
        cov = cov_in;
        if (widen)
            for (k = 0; k < span; k++)
                if (cov_history[k] > cov) cov = cov_history[k];
        // raw bytes enter the window even with widening off
        for (k = WINDOW - 1; k > 0; k--) cov_history[k] = cov_history[k-1];
        cov_history[0] = cov_in;
        if (cov == 0) begin
            r = '0;
        end else begin
            base = over_dest ? dest : bg_argb;
            if (base == 0) base = ZERO_BASE;
            alpha = {1'b0, base[31:24]} + {1'b0, cov};
            if (alpha > {1'b0, CHAN_MAX}) alpha = {1'b0, CHAN_MAX};
            r.write_en = 1'b1;
            r.pixel = {alpha[7:0],
                       mix_channel(base[23:16], fg_rgb[23:16], cov),
                       mix_channel(base[15:8], fg_rgb[15:8], cov),
                       mix_channel(base[7:0], fg_rgb[7:0], cov)};
        end
        expected_pixels.push_back(r);
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            fg_rgb = '0;
            bg_argb = BG_RESET;
            over_dest = 1'b0;
            widen = 1'b0;
            spread_reg = SPREAD_RESET;
            foreach (cov_history[j]) cov_history[j] = '0;
            expected_pixels.delete();
        end else begin
            if (i_cfg_wr_en) begin
                case (i_cfg_index)
                    CFG_FG_COLOR:     fg_rgb = i_cfg_data[FG_W-1:0];
                    CFG_BG_COLOR:     bg_argb = i_cfg_data[PIX_W-1:0];
                    CFG_PER_PIXEL_BG: over_dest = i_cfg_data[0];
                    CFG_EMBOLDEN:     widen = i_cfg_data[0];
                    CFG_SPREAD_WIDTH: spread_reg = i_cfg_data[SPREAD_W-1:0];
                    default: ;
                endcase
            end
            if (i_m_tvalid && i_m_tready) begin
                seen.write_en = i_m_tuser;
                seen.pixel = i_m_tdata;
                if (expected_pixels.size() == 0) begin
                    report_mismatch("unexpected", i_m_tdata, '0);
                end else begin
                    due = expected_pixels.pop_front();
                    if (seen.write_en !== due.write_en)
                        report_mismatch("write flag", 32'(seen.write_en), 32'(due.write_en));
                    if (seen.pixel !== due.pixel)
                        report_mismatch("pixel", seen.pixel, due.pixel);
                    if (due.write_en) writes++;
                end
                results++;
            end
            if (i_s_tvalid && i_s_tready)
                predict_pixel(i_s_tdata[7:0], i_s_tdata[39:8], i_s_tuser);
        end
        o_pending <= expected_pixels.size();
        o_mismatches <= mismatches;
        o_results <= results;
        o_writes <= writes;
    end

endmodule

[sim/glyph_coverage_blend_embolden_test.sv]
`timescale 1ns / 1ps

module glyph_coverage_blend_embolden_test;
    import gcbe_pkg::*;

    localparam int CLK_HALF     = 10;
    localparam int RESET_CYCLES = 6;
    // two pipeline registers, plus margin
    localparam int SETTLE_CYCLES = 4;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int RANDOM_PHASES = 8;
    localparam int PHASE_ITEMS  = 85;
    // index with no register behind it, writes must be ignored
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 3'd7;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DAT_W-1:0]  i_cfg_data = '0;
    logic                  i_s_tvalid = 1'b0;
    logic                  o_s_tready;
    logic [39:0]           i_s_tdata = '0;  // coverage[7:0], dest_pixel[39:8]
    logic                  i_s_tuser = 1'b0;  // row_start
    logic                  o_m_tvalid;
    logic                  i_m_tready = 1'b0;
    logic [31:0]           o_m_tdata;  // new_pixel[31:0]
    logic                  o_m_tuser;  // write_enable

    int  mismatch_count;
    int  pending_results;
    int  result_count;
    int  write_count;
    int  sent_count = 0;
    int  setting_count = 0;
    int  cycle_count = 0;
    int  stall_left = 0;
    // last phase runs both sides flat out
    logic quiet_tail = 1'b0;

    always #(CLK_HALF) i_clk = ~i_clk;

    glyph_coverage_blend_embolden dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tuser   (o_m_tuser)
    );

    // watches both channels and the register port, predicts every pixel
    glyph_blend_checker checker_i (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_wr_en  (i_cfg_wr_en),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_s_tvalid   (i_s_tvalid),
        .i_s_tready   (o_s_tready),
        .i_s_tdata    (i_s_tdata),
        .i_s_tuser    (i_s_tuser),
        .i_m_tvalid   (o_m_tvalid),
        .i_m_tready   (i_m_tready),
        .i_m_tdata    (o_m_tdata),
        .i_m_tuser    (o_m_tuser),
        .o_mismatches (mismatch_count),
        .o_pending    (pending_results),
        .o_results    (result_count),
        .o_writes     (write_count)
    );

    // watchdog: a hung handshake ends the run as a failure
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, pending_results);
            $display("glyph_coverage_blend_embolden regression: fail");
            $finish;
        end
    end

    // downstream backpressure: random stall bursts
    always @(posedge i_clk) begin
        if (quiet_tail) begin
            i_m_tready <= 1'b1;
            stall_left <= 0;
        end else if (stall_left > 0) begin
            i_m_tready <= 1'b0;
            stall_left <= stall_left - 1;
        end else if ($urandom_range(0, 5) == 0) begin
            i_m_tready <= 1'b0;
            stall_left <= $urandom_range(0, 2);
        end else begin
            i_m_tready <= 1'b1;
        end
    end

    // one register write per cycle; the caller drops the enable after the last one
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] value);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        @(posedge i_clk);
    endtask

    // full register set; upper bits beyond each register's width are left as given
    task automatic load_setting(input logic [31:0] fg, input logic [31:0] bg,
                                input logic [31:0] over_dest, input logic [31:0] widen,
                                input logic [31:0] spread);
        write_reg(CFG_FG_COLOR, fg);
        write_reg(CFG_BG_COLOR, bg);
        write_reg(CFG_PER_PIXEL_BG, over_dest);
        write_reg(CFG_EMBOLDEN, widen);
        write_reg(CFG_SPREAD_WIDTH, spread);
        i_cfg_wr_en <= 1'b0;
        setting_count++;
    endtask

    // one pixel transaction, with an optional idle burst ahead of it
    task automatic send_pixel(input logic [7:0] cov, input logic [31:0] dest,
                              input logic first_col);
        if (!quiet_tail && $urandom_range(0, 4) == 0) begin
            i_s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= {dest, cov};
        i_s_tuser  <= first_col;
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        sent_count++;
    endtask

    // stop sending and let every predicted pixel come out before touching registers
    task automatic drain_pipeline;
        i_s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending_results != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // glyph rows: row start on the first column, mixed coverage with padding zeros;
    // about one row in ten is noise with row start at random
    task automatic send_glyph_rows(input int count);
        int          left;
        int          row_len;
        int          col;
        logic        broken;
        logic        first_col;
        logic [7:0]  cov;
        logic [31:0] dest;
        left = count;
        while (left > 0) begin
            row_len = $urandom_range(2, 14);
            broken = ($urandom_range(0, 9) == 0);
            for (col = 0; col < row_len && left > 0; col++) begin
                case ($urandom_range(0, 7))
                    0, 1:    cov = 8'h00;
                    2:       cov = 8'hFF;
                    default: cov = 8'($urandom);
                endcase
                // trailing padding column
                if (col == row_len - 1 && $urandom_range(0, 1) == 0) cov = 8'h00;
                case ($urandom_range(0, 9))
                    0:       dest = 32'h0000_0000;
                    1:       dest = {8'hFF, 24'($urandom)};
                    default: dest = $urandom;
                endcase
                first_col = broken ? 1'($urandom) : (col == 0);
                send_pixel(cov, dest, first_col);
                left--;
            end
        end
    endtask

    initial begin
        int phase;

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset settings: black text over the default gray background
        send_pixel(8'h00, 32'h1234_5678, 1'b1);   // zero coverage, no write
        send_pixel(8'hFF, 32'h0000_0000, 1'b0);
        send_pixel(8'h01, 32'hFFFF_FFFF, 1'b0);
        drain_pipeline();

        // white text, zero background register stands in for gray,
        // junk in the unused foreground bits
        load_setting(32'hFFFF_FFFF, 32'h0000_0000, 32'h0, 32'h0, 32'h1);
        send_pixel(8'hFF, 32'hDEAD_BEEF, 1'b1);
        send_pixel(8'h80, 32'h0000_0000, 1'b0);
        send_pixel(8'h01, 32'hFFFF_FFFF, 1'b0);
        send_pixel(8'h00, 32'hFFFF_FFFF, 1'b0);
        drain_pipeline();

        // blend over the destination: zero destination, alpha saturation;
        // widening off but the window still fills
        load_setting(32'hA500_FF00, 32'h1234_5678, 32'hFFFF_FFFF, 32'h0, 32'h3);
        send_pixel(8'hFF, 32'h0000_0000, 1'b1);
        send_pixel(8'hC8, 32'hFFFF_FFFF, 1'b0);
        send_pixel(8'h3C, 32'h0000_0001, 1'b0);
        drain_pipeline();

        // widening on with spread 3: history from the last phase shows up,
        // then a row start wipes it
        load_setting(32'h00FF_00FF, 32'hFF00_FF00, 32'h0, 32'h1, 32'h3);
        send_pixel(8'h00, $urandom, 1'b0);
        send_pixel(8'h00, $urandom, 1'b0);
        send_pixel(8'h00, $urandom, 1'b1);
        send_pixel(8'h5A, $urandom, 1'b0);
        send_pixel(8'h00, $urandom, 1'b0);
        send_pixel(8'h00, $urandom, 1'b0);
        drain_pipeline();

        // spread 0 behaves as 1; a write to a spare index must change nothing
        load_setting(32'h0080_40C0, 32'h7F01_02FE, 32'h0, 32'h1, 32'h0);
        @(posedge i_clk);
        write_reg(CFG_SPARE, $urandom);
        i_cfg_wr_en <= 1'b0;
        send_pixel(8'h00, $urandom, 1'b1);
        send_pixel(8'h4D, $urandom, 1'b0);
        send_pixel(8'h00, $urandom, 1'b0);
        send_pixel(8'h00, $urandom, 1'b0);
        drain_pipeline();

        // random part: extremes first, random registers in between,
        // oversized spread with no idling at the end
        for (phase = 0; phase < RANDOM_PHASES; phase++) begin
            case (phase)
                0: load_setting(32'h0, 32'hFFFF_FFFF, 32'h0, 32'h1, 32'h8);
                1: load_setting(32'h00FF_FFFF, 32'h0, 32'h1, 32'h1, 32'h1);
                RANDOM_PHASES - 1: begin
                    load_setting($urandom, $urandom, 32'h1, 32'h1, 32'hF);
                    quiet_tail <= 1'b1;
                end
                default: load_setting($urandom, $urandom, $urandom, $urandom, $urandom);
            endcase
            send_glyph_rows(PHASE_ITEMS);
            drain_pipeline();
        end

        $display("covered %0d pixel transactions over %0d register settings",
                 sent_count, setting_count);
        $display("%0d results checked, %0d of them blended writes",
                 result_count, write_count);
        if (mismatch_count == 0) begin
            $display("glyph_coverage_blend_embolden regression: pass");
        end else begin
            $display("%0d mismatches", mismatch_count);
            $display("glyph_coverage_blend_embolden regression: fail");
        end
        $finish;
    end

endmodule
